/* sv/rrj_pkg.sv */
// Shared types, constants and fixed-point helpers for the reprojection Jacobian unit.
package rrj_pkg;

    localparam int unsigned QB = 30;

    localparam logic [1:0] ROW_RES = 2'd0;
    localparam logic [1:0] ROW_J0  = 2'd1;
    localparam logic [1:0] ROW_J1  = 2'd2;

    localparam logic [1:0] REG_INFO00 = 2'd0;
    localparam logic [1:0] REG_INFO01 = 2'd1;
    localparam logic [1:0] REG_INFO10 = 2'd2;
    localparam logic [1:0] REG_INFO11 = 2'd3;

    localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
    localparam logic signed [71:0] SAT_LO = -72'sd2147483648;
    localparam logic signed [71:0] QONE   = 72'sd1073741824;

    typedef logic [31:0] t_w32;
    typedef t_w32 [2:0][2:0] t_mat;

    typedef struct packed {
        t_mat rot;
        t_mat mrot;
        t_w32 obs_u;
        t_w32 obs_v;
        t_w32 den;
        logic zero;
    } t_side1;

    typedef struct packed {
        t_mat rot;
        t_mat mrot;
        t_w32 kq;
        t_w32 r0;
        t_w32 r1;
        logic zero;
    } t_side2;

    // Exact product shifted right with rounding toward minus infinity.
    function automatic logic signed [65:0] mulq(input logic signed [32:0] a,
                                               input logic signed [32:0] b,
                                               input int unsigned s);
        logic signed [65:0] p;
        p = a * b;
        return p >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

/* sv/rrj_in_if.sv */
// Input channel carrying one pose, world point and observation per beat.
interface rrj_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_tx;
    logic signed [31:0] pose_ty;
    logic signed [31:0] pose_tz;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] obs_u;
    logic signed [31:0] obs_v;

    modport source (
        output valid, pose_tx, pose_ty, pose_tz, quat_x, quat_y, quat_z, quat_w,
               point_x, point_y, point_z, obs_u, obs_v,
        input  ready
    );
    modport sink (
        input  valid, pose_tx, pose_ty, pose_tz, quat_x, quat_y, quat_z, quat_w,
               point_x, point_y, point_z, obs_u, obs_v,
        output ready
    );
endinterface

/* sv/rrj_out_if.sv */
// Result channel carrying one residual or Jacobian row per beat.
interface rrj_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_kind;
    logic               last;
    logic               status;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic signed [31:0] value_4;
    logic signed [31:0] value_5;
    logic signed [31:0] value_6;
    logic signed [31:0] value_7;
    logic signed [31:0] value_8;

    modport source (
        output valid, row_kind, last, status, value_0, value_1, value_2, value_3,
               value_4, value_5, value_6, value_7, value_8,
        input  ready
    );
    modport sink (
        input  valid, row_kind, last, status, value_0, value_1, value_2, value_3,
               value_4, value_5, value_6, value_7, value_8,
        output ready
    );
endinterface

/* sv/rrj_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating to 32 bits.
module rrj_div #(
    parameter int ND = 1,
    parameter int DW = 49,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [ND-1:0][DW-1:0]  i_num,
    input  logic [31:0]            i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_vld,
    output logic [ND-1:0][31:0]    o_quo,
    output logic [SW-1:0]          o_side
);
    localparam int NSTEP = 32;
    localparam int NST   = NSTEP + 3;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    logic [NST-1:0] r_v;
    logic [SW-1:0]  r_sd [NST];

    logic [DW-1:0] r0_mag [ND];
    logic          r0_neg [ND];
    logic [31:0]   r0_dmag;

    logic [31:0] r_rem [NSTEP+1][ND];
    logic [31:0] r_low [NSTEP+1][ND];
    logic [31:0] r_dm  [NSTEP+1];
    logic        r_ng  [NSTEP+1][ND];
    logic        r_of  [NSTEP+1][ND];
    logic [31:0] r_q   [ND];

    logic [DW-1:0] n0_mag [ND];
    logic          n0_neg [ND];
    logic [31:0]   n0_dmag;
    logic [31:0]   n1_rem [ND];
    logic [31:0]   n1_low [ND];
    logic          n1_of  [ND];
    logic [31:0]   n_rem  [NSTEP][ND];
    logic [31:0]   n_low  [NSTEP][ND];
    logic [31:0]   n_q    [ND];

    always_comb begin
        logic [32:0] w_t;
        logic        w_ge;
        logic [31:0] w_qq;
        n0_dmag = i_den[31] ? 32'(-$signed(i_den)) : i_den;
        for (int l = 0; l < ND; l++) begin
            n0_mag[l] = i_num[l][DW-1] ? DW'(-$signed(i_num[l])) : i_num[l];
            n0_neg[l] = (i_den == '0) ? i_num[l][DW-1] : (i_num[l][DW-1] ^ i_den[31]);
            n1_of[l]  = 32'(r0_mag[l][DW-1:32]) >= r0_dmag;
            n1_rem[l] = n1_of[l] ? '0 : 32'(r0_mag[l][DW-1:32]);
            n1_low[l] = r0_mag[l][31:0];
        end
        for (int k = 0; k < NSTEP; k++) begin
            for (int l = 0; l < ND; l++) begin
                w_t  = {r_rem[k][l], r_low[k][l][31]};
                w_ge = w_t >= {1'b0, r_dm[k]};
                n_rem[k][l] = w_ge ? 32'(w_t - {1'b0, r_dm[k]}) : w_t[31:0];
                n_low[k][l] = {r_low[k][l][30:0], w_ge};
            end
        end
        for (int l = 0; l < ND; l++) begin
            w_qq = r_low[NSTEP][l];
            if (r_of[NSTEP][l]) begin
                n_q[l] = r_ng[NSTEP][l] ? Q_MIN : Q_MAX;
            end else if (r_ng[NSTEP][l]) begin
                n_q[l] = (w_qq[31] && (w_qq[30:0] != '0)) ? Q_MIN : 32'(32'd0 - w_qq);
            end else begin
                n_q[l] = w_qq[31] ? Q_MAX : w_qq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int i = 1; i < NST; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r0_mag   <= n0_mag;
            r0_neg   <= n0_neg;
            r0_dmag  <= n0_dmag;
            r_rem[0] <= n1_rem;
            r_low[0] <= n1_low;
            r_of[0]  <= n1_of;
            r_ng[0]  <= r0_neg;
            r_dm[0]  <= r0_dmag;
            for (int k = 0; k < NSTEP; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_low[k+1] <= n_low[k];
                r_of[k+1]  <= r_of[k];
                r_ng[k+1]  <= r_ng[k];
                r_dm[k+1]  <= r_dm[k];
            end
            r_q <= n_q;
        end
    end

    always_comb begin
        for (int l = 0; l < ND; l++) begin
            o_quo[l] = r_q[l];
        end
    end

    assign o_vld  = r_v[NST-1];
    assign o_side = r_sd[NST-1];

endmodule

/* sv/reprojection_residual_jacobian_unit.sv */
// Top level of the pinhole reprojection residual and Jacobian unit.
// The two 35-stage dividers dominate the latency; each stage takes a new item per cycle
// while not stalled. The pipeline advances only while the output holds no item or its last
// result beat is taken, so the three result beats of each item bound the input rate.
// Reset (synchronous, active low) empties the pipeline and sets the information matrix to I.
module reprojection_residual_jacobian_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrj_in_if.sink       i_in,
    rrj_out_if.source    o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rrj_pkg::*;

    localparam int DW = 33 + FRAC_BITS;
    localparam int unsigned FB = FRAC_BITS;

    logic signed [31:0] r_info [4];

    logic w_en;

    logic               r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    logic signed [31:0] r1_t [3];
    logic signed [31:0] r1_q [4];
    logic signed [31:0] r1_p [3];
    logic signed [31:0] r1_obs [2];

    logic signed [33:0] r2_qq [9];
    logic signed [33:0] n2_qq [9];
    logic signed [31:0] r2_t [3];
    logic signed [31:0] r2_p [3];
    logic signed [31:0] r2_obs [2];

    t_mat               r3_rot, n3_rot;
    logic signed [31:0] r3_t [3];
    logic signed [31:0] r3_p [3];
    logic signed [31:0] r3_obs [2];

    logic signed [34:0] r4_pt [3][3];
    logic signed [34:0] r4_mt [3][3][2];
    logic signed [34:0] n4_pt [3][3];
    logic signed [34:0] n4_mt [3][3][2];
    t_mat               r4_rot;
    logic signed [31:0] r4_t [3];
    logic signed [31:0] r4_obs [2];

    logic signed [31:0] r5_pc [3];
    logic signed [31:0] n5_pc [3];
    t_mat               r5_m, n5_m;
    t_mat               r5_rot;
    logic signed [31:0] r5_obs [2];

    logic [2:0][DW-1:0] w_num1;
    t_side1             w_s1_in, w_s1_out;
    logic               w_d1_vld;
    logic [2:0][31:0]   w_q1;

    logic signed [32:0] r6_na, r6_nb;
    logic [31:0]        r6_den;
    t_side2             r6_side, n6_side;

    logic [1:0][DW-1:0] w_num2;
    t_side2             w_s2_out;
    logic               w_d2_vld;
    logic [1:0][31:0]   w_q2;

    logic signed [63:0] r7_pr  [2][2];
    logic signed [63:0] r7_pk  [2][2];
    logic signed [63:0] r7_pab [2][2];
    logic signed [63:0] n7_pr  [2][2];
    logic signed [63:0] n7_pk  [2][2];
    logic signed [63:0] n7_pab [2][2];
    t_mat               r7_rot, r7_m;
    logic               r7_zero;

    logic signed [31:0] r8_res [2];
    logic signed [31:0] r8_w [2][3];
    logic signed [31:0] n8_res [2];
    logic signed [31:0] n8_w [2][3];
    t_mat               r8_rot, r8_m;
    logic               r8_zero;

    logic signed [63:0] r9_wm [2][3][3];
    logic signed [63:0] r9_wr [2][3][3];
    logic signed [63:0] n9_wm [2][3][3];
    logic signed [63:0] n9_wr [2][3][3];
    logic signed [31:0] r9_w [2][3];
    logic signed [31:0] r9_res [2];
    logic               r9_zero;

    logic               r_ov;
    logic [1:0]         r_beat;
    logic signed [31:0] r_res [2];
    logic signed [31:0] r_jac [2][9];
    logic signed [31:0] n_jac [2][9];
    logic               r_zero;
    logic signed [31:0] w_val [9];

    assign pready = 1'b1;
    assign prdata = r_info[paddr[3:2]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info[REG_INFO00] <= 32'sd1 <<< FRAC_BITS;
            r_info[REG_INFO01] <= '0;
            r_info[REG_INFO10] <= '0;
            r_info[REG_INFO11] <= 32'sd1 <<< FRAC_BITS;
        end else if (psel && penable && pwrite) begin
            r_info[paddr[3:2]] <= $signed(pwdata);
        end
    end

    assign w_en       = !r_ov || (o_res.ready && (r_beat == ROW_J1));
    assign i_in.ready = w_en;

    always_comb begin
        logic signed [32:0] w_np [3];
        n2_qq[0] = 34'(mulq(33'(r1_q[0]), 33'(r1_q[0]), QB));
        n2_qq[1] = 34'(mulq(33'(r1_q[1]), 33'(r1_q[1]), QB));
        n2_qq[2] = 34'(mulq(33'(r1_q[2]), 33'(r1_q[2]), QB));
        n2_qq[3] = 34'(mulq(33'(r1_q[0]), 33'(r1_q[1]), QB));
        n2_qq[4] = 34'(mulq(33'(r1_q[0]), 33'(r1_q[2]), QB));
        n2_qq[5] = 34'(mulq(33'(r1_q[1]), 33'(r1_q[2]), QB));
        n2_qq[6] = 34'(mulq(33'(r1_q[3]), 33'(r1_q[0]), QB));
        n2_qq[7] = 34'(mulq(33'(r1_q[3]), 33'(r1_q[1]), QB));
        n2_qq[8] = 34'(mulq(33'(r1_q[3]), 33'(r1_q[2]), QB));

        n3_rot[0][0] = sat32(QONE - 72'sd2 * (72'(r2_qq[1]) + 72'(r2_qq[2])));
        n3_rot[0][1] = sat32(72'sd2 * (72'(r2_qq[3]) - 72'(r2_qq[8])));
        n3_rot[0][2] = sat32(72'sd2 * (72'(r2_qq[4]) + 72'(r2_qq[7])));
        n3_rot[1][0] = sat32(72'sd2 * (72'(r2_qq[3]) + 72'(r2_qq[8])));
        n3_rot[1][1] = sat32(QONE - 72'sd2 * (72'(r2_qq[0]) + 72'(r2_qq[2])));
        n3_rot[1][2] = sat32(72'sd2 * (72'(r2_qq[5]) - 72'(r2_qq[6])));
        n3_rot[2][0] = sat32(72'sd2 * (72'(r2_qq[4]) - 72'(r2_qq[7])));
        n3_rot[2][1] = sat32(72'sd2 * (72'(r2_qq[5]) + 72'(r2_qq[6])));
        n3_rot[2][2] = sat32(QONE - 72'sd2 * (72'(r2_qq[0]) + 72'(r2_qq[1])));

        for (int j = 0; j < 3; j++) begin
            w_np[j] = -33'(r3_p[j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n4_pt[i][j] = 35'(mulq(33'($signed(r3_rot[i][j])), 33'(r3_p[j]), QB));
            end
            n4_mt[i][0][0] = 35'(mulq(33'($signed(r3_rot[i][1])), 33'(r3_p[2]), QB));
            n4_mt[i][0][1] = 35'(mulq(33'($signed(r3_rot[i][2])), w_np[1], QB));
            n4_mt[i][1][0] = 35'(mulq(33'($signed(r3_rot[i][0])), w_np[2], QB));
            n4_mt[i][1][1] = 35'(mulq(33'($signed(r3_rot[i][2])), 33'(r3_p[0]), QB));
            n4_mt[i][2][0] = 35'(mulq(33'($signed(r3_rot[i][0])), 33'(r3_p[1]), QB));
            n4_mt[i][2][1] = 35'(mulq(33'($signed(r3_rot[i][1])), w_np[0], QB));
        end

        for (int i = 0; i < 3; i++) begin
            n5_pc[i] = sat32(72'(r4_t[i]) + 72'(r4_pt[i][0]) + 72'(r4_pt[i][1])
                             + 72'(r4_pt[i][2]));
            for (int c = 0; c < 3; c++) begin
                n5_m[i][c] = sat32(72'sd0 - 72'(r4_mt[i][c][0]) - 72'(r4_mt[i][c][1]));
            end
        end
    end

    always_comb begin
        w_num1[0] = DW'(r5_pc[0]) <<< FRAC_BITS;
        w_num1[1] = DW'(r5_pc[1]) <<< FRAC_BITS;
        w_num1[2] = DW'(1) << (2 * FRAC_BITS);
        w_s1_in.rot   = r5_rot;
        w_s1_in.mrot  = r5_m;
        w_s1_in.obs_u = r5_obs[0];
        w_s1_in.obs_v = r5_obs[1];
        w_s1_in.den   = r5_pc[2];
        w_s1_in.zero  = (r5_pc[2] == '0);
    end

    rrj_div #(.ND(3), .DW(DW), .SW($bits(t_side1))) u_div_proj (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r5_v),
        .i_num  (w_num1),
        .i_den  (r5_pc[2]),
        .i_side (w_s1_in),
        .o_vld  (w_d1_vld),
        .o_quo  (w_q1),
        .o_side (w_s1_out)
    );

    always_comb begin
        n6_side.rot  = w_s1_out.rot;
        n6_side.mrot = w_s1_out.mrot;
        n6_side.kq   = w_q1[2];
        n6_side.r0   = sat32(72'($signed(w_q1[0])) - 72'($signed(w_s1_out.obs_u)));
        n6_side.r1   = sat32(72'($signed(w_q1[1])) - 72'($signed(w_s1_out.obs_v)));
        n6_side.zero = w_s1_out.zero;
        w_num2[0] = DW'(r6_na) <<< FRAC_BITS;
        w_num2[1] = DW'(r6_nb) <<< FRAC_BITS;
    end

    rrj_div #(.ND(2), .DW(DW), .SW($bits(t_side2))) u_div_grad (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r6_v),
        .i_num  (w_num2),
        .i_den  (r6_den),
        .i_side (r6_side),
        .o_vld  (w_d2_vld),
        .o_quo  (w_q2),
        .o_side (w_s2_out)
    );

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n7_pr[i][0]  = 64'(mulq(33'(r_info[2*i]), 33'($signed(w_s2_out.r0)), FB));
            n7_pr[i][1]  = 64'(mulq(33'(r_info[2*i+1]), 33'($signed(w_s2_out.r1)), FB));
            n7_pk[i][0]  = 64'(mulq(33'(r_info[2*i]), 33'($signed(w_s2_out.kq)), FB));
            n7_pk[i][1]  = 64'(mulq(33'(r_info[2*i+1]), 33'($signed(w_s2_out.kq)), FB));
            n7_pab[i][0] = 64'(mulq(33'(r_info[2*i]), 33'($signed(w_q2[0])), FB));
            n7_pab[i][1] = 64'(mulq(33'(r_info[2*i+1]), 33'($signed(w_q2[1])), FB));
        end
        for (int i = 0; i < 2; i++) begin
            n8_res[i]  = sat32(72'(r7_pr[i][0]) + 72'(r7_pr[i][1]));
            n8_w[i][0] = sat32(72'(r7_pk[i][0]));
            n8_w[i][1] = sat32(72'(r7_pk[i][1]));
            n8_w[i][2] = sat32(72'(r7_pab[i][0]) + 72'(r7_pab[i][1]));
        end
        for (int i = 0; i < 2; i++) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) begin
                    n9_wm[i][c][j] = 64'(mulq(33'(r8_w[i][j]), 33'($signed(r8_m[j][c])), FB));
                    n9_wr[i][c][j] = 64'(mulq(33'(r8_w[i][j]), 33'($signed(r8_rot[j][c])),
                                              QB));
                end
            end
        end
        for (int i = 0; i < 2; i++) begin
            for (int c = 0; c < 3; c++) begin
                n_jac[i][c]   = r9_w[i][c];
                n_jac[i][3+c] = sat32(72'(r9_wm[i][c][0]) + 72'(r9_wm[i][c][1])
                                      + 72'(r9_wm[i][c][2]));
                n_jac[i][6+c] = sat32(72'(r9_wr[i][c][0]) + 72'(r9_wr[i][c][1])
                                      + 72'(r9_wr[i][c][2]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r6_v   <= 1'b0;
            r7_v   <= 1'b0;
            r8_v   <= 1'b0;
            r9_v   <= 1'b0;
            r_ov   <= 1'b0;
            r_beat <= ROW_RES;
        end else if (w_en) begin
            r1_v   <= i_in.valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r6_v   <= w_d1_vld;
            r7_v   <= w_d2_vld;
            r8_v   <= r7_v;
            r9_v   <= r8_v;
            r_ov   <= r9_v;
            r_beat <= ROW_RES;
        end else if (o_res.ready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_t[0]   <= i_in.pose_tx;
            r1_t[1]   <= i_in.pose_ty;
            r1_t[2]   <= i_in.pose_tz;
            r1_q[0]   <= i_in.quat_x;
            r1_q[1]   <= i_in.quat_y;
            r1_q[2]   <= i_in.quat_z;
            r1_q[3]   <= i_in.quat_w;
            r1_p[0]   <= i_in.point_x;
            r1_p[1]   <= i_in.point_y;
            r1_p[2]   <= i_in.point_z;
            r1_obs[0] <= i_in.obs_u;
            r1_obs[1] <= i_in.obs_v;

            r2_qq  <= n2_qq;
            r2_t   <= r1_t;
            r2_p   <= r1_p;
            r2_obs <= r1_obs;

            r3_rot <= n3_rot;
            r3_t   <= r2_t;
            r3_p   <= r2_p;
            r3_obs <= r2_obs;

            r4_pt  <= n4_pt;
            r4_mt  <= n4_mt;
            r4_rot <= r3_rot;
            r4_t   <= r3_t;
            r4_obs <= r3_obs;

            r5_pc  <= n5_pc;
            r5_m   <= n5_m;
            r5_rot <= r4_rot;
            r5_obs <= r4_obs;

            r6_na   <= -33'($signed(w_q1[0]));
            r6_nb   <= -33'($signed(w_q1[1]));
            r6_den  <= w_s1_out.den;
            r6_side <= n6_side;

            r7_pr   <= n7_pr;
            r7_pk   <= n7_pk;
            r7_pab  <= n7_pab;
            r7_rot  <= w_s2_out.rot;
            r7_m    <= w_s2_out.mrot;
            r7_zero <= w_s2_out.zero;

            r8_res  <= n8_res;
            r8_w    <= n8_w;
            r8_rot  <= r7_rot;
            r8_m    <= r7_m;
            r8_zero <= r7_zero;

            r9_wm   <= n9_wm;
            r9_wr   <= n9_wr;
            r9_w    <= r8_w;
            r9_res  <= r8_res;
            r9_zero <= r8_zero;

            r_jac  <= n_jac;
            r_res  <= r9_res;
            r_zero <= r9_zero;
        end
    end

    always_comb begin
        unique case (r_beat)
            ROW_RES: begin
                w_val[0] = r_res[0];
                w_val[1] = r_res[1];
                for (int c = 2; c < 9; c++) begin
                    w_val[c] = '0;
                end
            end
            ROW_J0: begin
                w_val = r_jac[0];
            end
            ROW_J1: begin
                w_val = r_jac[1];
            end
            default: begin
                for (int c = 0; c < 9; c++) begin
                    w_val[c] = '0;
                end
            end
        endcase
    end

    assign o_res.valid    = r_ov;
    assign o_res.row_kind = r_beat;
    assign o_res.last     = (r_beat == ROW_J1);
    assign o_res.status   = r_zero;
    assign o_res.value_0  = w_val[0];
    assign o_res.value_1  = w_val[1];
    assign o_res.value_2  = w_val[2];
    assign o_res.value_3  = w_val[3];
    assign o_res.value_4  = w_val[4];
    assign o_res.value_5  = w_val[5];
    assign o_res.value_6  = w_val[6];
    assign o_res.value_7  = w_val[7];
    assign o_res.value_8  = w_val[8];

endmodule

/* verif/rrj_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts residual and Jacobian beats and compares them with the block's results.
module rrj_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrj_in_if           in_mon,
    rrj_out_if          res_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    import rrj_pkg::*;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct {
        logic [1:0] kind;
        logic       last;
        logic       status;
        logic [31:0] val [9];
    } t_row;

    t_row   rows_due [$];
    longint info [2][2];

    function automatic longint clamp32(input longint v);
        if (v > I32_MAX) return I32_MAX;
        if (v < I32_MIN) return I32_MIN;
        return v;
    endfunction

    function automatic longint fmul(input longint a, input longint b, input int s);
        longint p;
        p = a * b;
        return p >>> s;
    endfunction

    function automatic longint depth_div(input longint n, input longint d);
        if (d == 0) return (n >= 0) ? I32_MAX : I32_MIN;
        return clamp32(n / d);
    endfunction

    task automatic predict_rows();
        longint one, qone, t [3], p [3], pc [3], rot [3][3], mrot [3][3], sk [3][3];
        longint wd [2][3], qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint pu, pv, r0, r1, k, a, b, res [2], s, sr, sp;
        logic   zero;
        t_row   r;
        one  = longint'(1) <<< FRAC_BITS;
        qone = longint'(1) <<< 30;
        t[0] = in_mon.pose_tx;  t[1] = in_mon.pose_ty;  t[2] = in_mon.pose_tz;
        p[0] = in_mon.point_x;  p[1] = in_mon.point_y;  p[2] = in_mon.point_z;
        qx = in_mon.quat_x;  qy = in_mon.quat_y;  qz = in_mon.quat_z;  qw = in_mon.quat_w;
        xx = fmul(qx, qx, 30);  yy = fmul(qy, qy, 30);  zz = fmul(qz, qz, 30);
        xy = fmul(qx, qy, 30);  xz = fmul(qx, qz, 30);  yz = fmul(qy, qz, 30);
        wx = fmul(qw, qx, 30);  wy = fmul(qw, qy, 30);  wz = fmul(qw, qz, 30);
        rot[0][0] = clamp32(qone - 2 * (yy + zz));
        rot[0][1] = clamp32(2 * (xy - wz));
        rot[0][2] = clamp32(2 * (xz + wy));
        rot[1][0] = clamp32(2 * (xy + wz));
        rot[1][1] = clamp32(qone - 2 * (xx + zz));
        rot[1][2] = clamp32(2 * (yz - wx));
        rot[2][0] = clamp32(2 * (xz - wy));
        rot[2][1] = clamp32(2 * (yz + wx));
        rot[2][2] = clamp32(qone - 2 * (xx + yy));
        for (int i = 0; i < 3; i++) begin
            s = t[i];
            for (int j = 0; j < 3; j++) s += fmul(rot[i][j], p[j], 30);
            pc[i] = clamp32(s);
        end
        zero = (pc[2] == 0);
        pu = depth_div(pc[0] * one, pc[2]);
        pv = depth_div(pc[1] * one, pc[2]);
        r0 = clamp32(pu - longint'(in_mon.obs_u));
        r1 = clamp32(pv - longint'(in_mon.obs_v));
        for (int i = 0; i < 2; i++)
            res[i] = clamp32(fmul(info[i][0], r0, FRAC_BITS) + fmul(info[i][1], r1, FRAC_BITS));
        k = depth_div(longint'(1) <<< (2 * FRAC_BITS), pc[2]);
        a = depth_div(-pu * one, pc[2]);
        b = depth_div(-pv * one, pc[2]);
        for (int i = 0; i < 2; i++) begin
            wd[i][0] = clamp32(fmul(info[i][0], k, FRAC_BITS));
            wd[i][1] = clamp32(fmul(info[i][1], k, FRAC_BITS));
            wd[i][2] = clamp32(fmul(info[i][0], a, FRAC_BITS)
                               + fmul(info[i][1], b, FRAC_BITS));
        end
        sk[0][0] = 0;     sk[0][1] = -p[2]; sk[0][2] = p[1];
        sk[1][0] = p[2];  sk[1][1] = 0;     sk[1][2] = -p[0];
        sk[2][0] = -p[1]; sk[2][1] = p[0];  sk[2][2] = 0;
        for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++) begin
                s = 0;
                for (int j = 0; j < 3; j++) s += fmul(rot[i][j], sk[j][c], 30);
                mrot[i][c] = clamp32(-s);
            end
        r.kind = ROW_RES;
        r.last = 1'b0;
        r.status = zero;
        foreach (r.val[c]) r.val[c] = '0;
        r.val[0] = res[0][31:0];
        r.val[1] = res[1][31:0];
        rows_due.push_back(r);
        for (int i = 0; i < 2; i++) begin
            r.kind = (i == 0) ? ROW_J0 : ROW_J1;
            r.last = (i == 1);
            for (int c = 0; c < 3; c++) begin
                sr = 0;
                sp = 0;
                for (int j = 0; j < 3; j++) begin
                    sr += fmul(wd[i][j], mrot[j][c], FRAC_BITS);
                    sp += fmul(wd[i][j], rot[j][c], 30);
                end
                r.val[c]     = wd[i][c][31:0];
                r.val[3 + c] = 32'(clamp32(sr));
                r.val[6 + c] = 32'(clamp32(sp));
            end
            rows_due.push_back(r);
        end
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        o_fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic check_row();
        t_row e;
        logic [31:0] got [9];
        got = '{res_mon.value_0, res_mon.value_1, res_mon.value_2, res_mon.value_3,
                res_mon.value_4, res_mon.value_5, res_mon.value_6, res_mon.value_7,
                res_mon.value_8};
        if (rows_due.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected result beat, expected none, actual kind %0d",
                     $time, res_mon.row_kind);
            return;
        end
        e = rows_due.pop_front();
        if (res_mon.row_kind !== e.kind) report("row_kind", e.kind, res_mon.row_kind);
        if (res_mon.last !== e.last) report("last", e.last, res_mon.last);
        if (res_mon.status !== e.status) report("status", e.status, res_mon.status);
        for (int c = 0; c < 9; c++)
            if (got[c] !== e.val[c]) report($sformatf("value_%0d", c), e.val[c], got[c]);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        info[0][0] = longint'(1) <<< FRAC_BITS;
        info[0][1] = 0;
        info[1][0] = 0;
        info[1][1] = longint'(1) <<< FRAC_BITS;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_INFO00: info[0][0] = longint'($signed(pwdata));
                    REG_INFO01: info[0][1] = longint'($signed(pwdata));
                    REG_INFO10: info[1][0] = longint'($signed(pwdata));
                    REG_INFO11: info[1][1] = longint'($signed(pwdata));
                    default: ;
                endcase
            end
            if (res_mon.valid && res_mon.ready) check_row();
            if (in_mon.valid && in_mon.ready) predict_rows();
        end
        o_pending = rows_due.size();
    end
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, register writes, pose stimulus and verdict.
module tb;
    import rrj_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending;
    bit          no_gaps;

    rrj_in_if  in_ch ();
    rrj_out_if res_ch ();

    reprojection_residual_jacobian_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rrj_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .res_mon      (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        paddr   = {idx, 2'b00};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic send_pose(input logic [31:0] f [12]);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {in_ch.pose_tx, in_ch.pose_ty, in_ch.pose_tz} = {f[0], f[1], f[2]};
        {in_ch.quat_x, in_ch.quat_y, in_ch.quat_z, in_ch.quat_w} = {f[3], f[4], f[5], f[6]};
        {in_ch.point_x, in_ch.point_y, in_ch.point_z} = {f[7], f[8], f[9]};
        {in_ch.obs_u, in_ch.obs_v} = {f[10], f[11]};
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_small(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_random(input int n);
        logic [31:0] f [12];
        int mode;
        for (int it = 0; it < n; it++) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                foreach (f[c]) f[c] = $urandom;
            end else begin
                f[0] = rnd_small(1 << 20);
                f[1] = rnd_small(1 << 20);
                f[2] = rnd_small(1 << 20);
                f[3] = rnd_small(1 << 29);
                f[4] = rnd_small(1 << 29);
                f[5] = rnd_small(1 << 29);
                f[6] = 32'sd1073741824 - 32'($urandom_range(0, 1 << 28));
                f[7] = rnd_small(1 << 22);
                f[8] = rnd_small(1 << 22);
                f[9] = 32'($urandom_range(1 << 16, 1 << 23));
                f[10] = rnd_small(1 << 17);
                f[11] = rnd_small(1 << 17);
                if (mode < 4) begin
                    f[3] = '0;
                    f[4] = '0;
                    f[5] = '0;
                    f[6] = 32'sd1073741824;
                    f[2] = -f[9];
                end
            end
            send_pose(f);
        end
    endtask

    task automatic send_directed();
        logic [31:0] f [12];
        foreach (f[c]) f[c] = '0;
        send_pose(f);
        foreach (f[c]) f[c] = 32'h7FFF_FFFF;
        send_pose(f);
        foreach (f[c]) f[c] = 32'h8000_0000;
        send_pose(f);
        foreach (f[c]) f[c] = 32'hFFFF_FFFF;
        send_pose(f);
        foreach (f[c]) f[c] = '0;
        f[6] = 32'sd1073741824;
        f[7] = 32'sd65536;
        f[8] = -32'sd131072;
        f[9] = 32'sd196608;
        send_pose(f);
        f[9] = -32'sd196608;
        send_pose(f);
        f[2] = 32'sd196608;
        send_pose(f);
        f[2] = 0;
        f[9] = 32'sd1;
        f[10] = 32'h7FFF_FFFF;
        f[11] = 32'h8000_0000;
        send_pose(f);
        f[3] = 32'h7FFF_FFFF;
        f[4] = 32'h8000_0000;
        f[5] = 32'h4000_0000;
        f[6] = 32'h7FFF_FFFF;
        f[9] = 32'sd655360;
        send_pose(f);
        f[7] = 32'h7FFF_FFFF;
        f[8] = 32'h8000_0000;
        f[9] = 32'h7FFF_FFFF;
        send_pose(f);
    endtask

    initial begin
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) stall = no_gaps ? 0 : $urandom_range(0, 5);
            @(negedge i_clk);
            res_ch.ready = (stall == 0) && i_rst_n;
            if (stall > 0) stall--;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_gaps = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.pose_tx, in_ch.pose_ty, in_ch.pose_tz, in_ch.quat_x, in_ch.quat_y,
         in_ch.quat_z, in_ch.quat_w, in_ch.point_x, in_ch.point_y, in_ch.point_z,
         in_ch.obs_u, in_ch.obs_v} = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_directed();
        send_random(100);
        no_gaps = 1'b1;
        send_random(30);
        no_gaps = 1'b0;
        in_ch.valid = 1'b0;
        drain();

        reg_write(REG_INFO00, 32'h7FFF_FFFF);
        reg_write(REG_INFO01, 32'h8000_0000);
        reg_write(REG_INFO10, 32'h8000_0000);
        reg_write(REG_INFO11, 32'h7FFF_FFFF);
        send_directed();
        send_random(60);
        in_ch.valid = 1'b0;
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            reg_write(REG_INFO00, rnd_small(1 << 18));
            reg_write(REG_INFO01, rnd_small(1 << 16));
            reg_write(REG_INFO10, rnd_small(1 << 16));
            reg_write(REG_INFO11, ph == 2 ? $urandom : rnd_small(1 << 18));
            no_gaps = (ph == 1);
            send_random(80);
            no_gaps = 1'b0;
            in_ch.valid = 1'b0;
            drain();
        end

        reg_write(REG_INFO00, '0);
        reg_write(REG_INFO01, '0);
        reg_write(REG_INFO10, '0);
        reg_write(REG_INFO11, '0);
        send_random(20);
        in_ch.valid = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/rrj_pkg.sv
sv/rrj_in_if.sv
sv/rrj_out_if.sv
sv/rrj_div.sv
sv/reprojection_residual_jacobian_unit.sv
verif/rrj_checker.sv
verif/tb.sv
